[hw/rtl/xover_pkg.sv]
package xover_pkg;

  localparam int SAMPLE_W         = 24;
  localparam int CHAN_W           = 3;
  localparam int COEF_W           = 18;
  localparam int COEF_REG_W       = 3 * COEF_W;
  localparam int YHIST_W          = 32;
  localparam int FILTERS          = 3;
  localparam int DEFAULT_CHANNELS = 8;
  localparam int QUEUE_DEPTH      = 4;

  // Configuration port: 64-bit registers at byte address 8*i.
  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 64;
  localparam int REG_SEL_LSB = 3;

  localparam logic [1:0] REG_ENABLE = 2'd0;
  localparam logic [1:0] REG_COEF_A = 2'd1;
  localparam logic [1:0] REG_COEF_B = 2'd2;
  localparam logic [1:0] REG_COEF_C = 2'd3;

  typedef struct packed {
    logic [CHAN_W-1:0]          chan;
    logic signed [SAMPLE_W-1:0] sample;
  } item_t;

  typedef logic [FILTERS-1:0][COEF_REG_W-1:0] coef_set_t;

  // Round a Q32.24 accumulator (Q.24 in) half up to Q.8 and clamp to 32 bits.
  function automatic logic signed [YHIST_W-1:0] sat_y(input logic signed [55:0] acc);
    logic signed [55:0] r;
    logic signed [39:0] t;
    r = acc + 56'sd32768;
    t = r[55:16];
    if (t > 40'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (t < -40'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return t[31:0];
    end
  endfunction

  // Round a Q.8 band value half up to an integer and clamp to 24 bits.
  function automatic logic signed [SAMPLE_W-1:0] band_out(input logic signed [33:0] q8);
    logic signed [34:0] r;
    logic signed [26:0] s;
    r = 35'(q8) + 35'sd128;
    s = r[34:8];
    if (s > 27'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (s < -27'sd8388608) begin
      return 24'sh800000;
    end else begin
      return s[23:0];
    end
  endfunction

endpackage

[hw/rtl/xover_front.sv]
module xover_front import xover_pkg::*; #(
  parameter int CHANNELS = DEFAULT_CHANNELS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       enable,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [CHAN_W-1:0]          channel,
  input  logic signed [SAMPLE_W-1:0] sample,
  output logic                       head_valid,
  output item_t                      head,
  input  logic                       pop
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  item_t            queue [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             keep;
  logic             push;
  logic             do_pop;

  // Items are taken while disabled or for a channel without history, and dropped.
  assign keep     = enable && ({29'd0, channel} < 32'(CHANNELS));
  assign in_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign push     = in_valid && in_ready && keep;
  assign do_pop   = pop && head_valid;

  assign head_valid = (count != '0);
  assign head       = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= '{chan: channel, sample: sample};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[hw/rtl/xover_back.sv]
module xover_back import xover_pkg::*; #(
  parameter int CHANNELS = DEFAULT_CHANNELS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  coef_set_t                  coefs,
  input  logic                       head_valid,
  input  item_t                      head,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [CHAN_W-1:0]          out_channel,
  output logic signed [SAMPLE_W-1:0] low_band,
  output logic signed [SAMPLE_W-1:0] mid_low_band,
  output logic signed [SAMPLE_W-1:0] mid_high_band,
  output logic signed [SAMPLE_W-1:0] high_band
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef struct packed {
    logic [SAMPLE_W-1:0]             x1;
    logic [SAMPLE_W-1:0]             x2;
    logic [FILTERS-1:0][YHIST_W-1:0] y1;
    logic [FILTERS-1:0][YHIST_W-1:0] y2;
  } row_t;

  function automatic logic [IDX_W-1:0] row_idx(input logic [CHAN_W-1:0] chan);
    logic [7:0] wide;
    wide = {5'd0, chan};
    return wide[IDX_W-1:0];
  endfunction

  // Per-channel history, one row per channel; a row never written reads as zero.
  row_t                hist [CHANNELS];
  logic [CHANNELS-1:0] row_valid;

  logic adv;
  logic hazard;
  logic issue;

  // Stage 1: history row and item.
  logic  s1_valid;
  item_t s1_item;
  row_t  s1_row;
  logic  s1_row_ok;
  row_t  row;
  logic signed [25:0] xsum;

  // Stage 2: products.
  logic                      s2_valid;
  item_t                     s2_item;
  logic [SAMPLE_W-1:0]       s2_x1;
  logic [FILTERS-1:0][YHIST_W-1:0] s2_y1;
  logic signed [43:0]        s2_pg  [FILTERS];
  logic signed [49:0]        s2_pa1 [FILTERS];
  logic signed [49:0]        s2_pa2 [FILTERS];
  logic signed [YHIST_W-1:0] yn     [FILTERS];
  logic [FILTERS-1:0][YHIST_W-1:0] yn_row;

  // Stage 3: filter outputs.
  logic                      s3_valid;
  item_t                     s3_item;
  logic signed [YHIST_W-1:0] s3_y [FILTERS];

  assign adv = !out_valid || out_ready;

  // The history of a channel is written as its item leaves stage 2, so a
  // later item of that channel waits while one is in stage 1 or 2.
  assign hazard = (s1_valid && (s1_item.chan == head.chan)) ||
                  (s2_valid && (s2_item.chan == head.chan));
  assign issue  = head_valid && adv && !hazard;
  assign pop    = issue;

  assign row  = s1_row_ok ? s1_row : '0;
  assign xsum = 26'($signed(s1_item.sample)) + (26'($signed(row.x1)) <<< 1)
              + 26'($signed(row.x2));

  always_comb begin
    for (int k = 0; k < FILTERS; k++) begin
      yn[k] = sat_y((56'(s2_pg[k]) <<< 8) - 56'(s2_pa1[k]) - 56'(s2_pa2[k]));
      yn_row[k] = yn[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
      row_valid <= '0;
    end else if (adv) begin
      s1_valid  <= issue;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      out_valid <= s3_valid;
      if (s2_valid) begin
        row_valid[row_idx(s2_item.chan)] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_item   <= head;
      s1_row    <= hist[row_idx(head.chan)];
      s1_row_ok <= row_valid[row_idx(head.chan)];

      s2_item <= s1_item;
      s2_x1   <= row.x1;
      s2_y1   <= row.y1;
      for (int k = 0; k < FILTERS; k++) begin
        s2_pg[k]  <= $signed(coefs[k][COEF_REG_W-1:2*COEF_W]) * xsum;
        s2_pa1[k] <= $signed(coefs[k][2*COEF_W-1:COEF_W]) * $signed(row.y1[k]);
        s2_pa2[k] <= $signed(coefs[k][COEF_W-1:0]) * $signed(row.y2[k]);
      end

      if (s2_valid) begin
        hist[row_idx(s2_item.chan)] <= '{x1: s2_item.sample, x2: s2_x1,
                                         y1: yn_row, y2: s2_y1};
      end

      s3_item <= s2_item;
      for (int k = 0; k < FILTERS; k++) begin
        s3_y[k] <= yn[k];
      end

      out_channel   <= s3_item.chan;
      low_band      <= band_out(34'(s3_y[0]));
      mid_low_band  <= band_out(34'(s3_y[1]) - 34'(s3_y[0]));
      mid_high_band <= band_out(34'(s3_y[2]) - 34'(s3_y[1]));
      high_band     <= band_out((34'(s3_item.sample) <<< 8) - 34'(s3_y[2]));
    end
  end

endmodule

[hw/rtl/four_band_iir_crossover.sv]
// Four-band audio crossover built from three second-order low-pass sections
// with per-channel history.
// Input channel: in_valid/in_ready with channel and sample. Output channel:
// out_valid/out_ready with out_channel and the four bands. Registers are
// written over the APB-style port at byte addresses 0 (enable), 8, 16 and 24
// (packed gain, a1, a2 of filters A, B and C); pready is always high.
// An item that arrives while disabled, or for a channel without history, is
// taken and produces no result.
// An accepted item goes from the queue through stages 1, 2 and 3 to the output
// register. Throughput is one item per cycle unless a hazard or receiver stall
// holds the pipeline. A later item of one channel waits at the queue head while
// an earlier one is in stage 1 or 2, as that channel's history is written back
// as it leaves stage 2; the waiting item and all behind it stay in the 4-entry queue.
// Reset disables the block, clears the coefficients and makes every channel's
// history read as zero. When the receiver stalls the result is held in the
// output register, the pipeline freezes, and the queue keeps taking items
// until it fills.
module four_band_iir_crossover import xover_pkg::*; #(
  parameter int CHANNELS = DEFAULT_CHANNELS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ADDR_W-1:0]          paddr,
  input  logic [DATA_W-1:0]          pwdata,
  output logic [DATA_W-1:0]          prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [CHAN_W-1:0]          channel,
  input  logic signed [SAMPLE_W-1:0] sample,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [CHAN_W-1:0]          out_channel,
  output logic signed [SAMPLE_W-1:0] low_band,
  output logic signed [SAMPLE_W-1:0] mid_low_band,
  output logic signed [SAMPLE_W-1:0] mid_high_band,
  output logic signed [SAMPLE_W-1:0] high_band
);

  logic       enable;
  coef_set_t  coefs;
  logic [1:0] reg_sel;
  logic       head_valid;
  item_t      head;
  logic       pop;

  assign pready  = 1'b1;
  assign reg_sel = paddr[ADDR_W-1:REG_SEL_LSB];

  always_ff @(posedge clk) begin
    if (rst) begin
      enable <= 1'b0;
      coefs  <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_ENABLE: enable   <= pwdata[0];
        REG_COEF_A: coefs[0] <= pwdata[COEF_REG_W-1:0];
        REG_COEF_B: coefs[1] <= pwdata[COEF_REG_W-1:0];
        REG_COEF_C: coefs[2] <= pwdata[COEF_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_ENABLE: prdata = {{(DATA_W-1){1'b0}}, enable};
      REG_COEF_A: prdata = {{(DATA_W-COEF_REG_W){1'b0}}, coefs[0]};
      REG_COEF_B: prdata = {{(DATA_W-COEF_REG_W){1'b0}}, coefs[1]};
      REG_COEF_C: prdata = {{(DATA_W-COEF_REG_W){1'b0}}, coefs[2]};
      default:    prdata = '0;
    endcase
  end

  xover_front #(.CHANNELS(CHANNELS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .enable     (enable),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .channel    (channel),
    .sample     (sample),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  xover_back #(.CHANNELS(CHANNELS)) u_back (
    .clk           (clk),
    .rst           (rst),
    .coefs         (coefs),
    .head_valid    (head_valid),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_channel   (out_channel),
    .low_band      (low_band),
    .mid_low_band  (mid_low_band),
    .mid_high_band (mid_high_band),
    .high_band     (high_band)
  );

endmodule

[test/four_band_iir_crossover_tb.sv]
`timescale 1ns / 100ps

module four_band_iir_crossover_tb;
  import xover_pkg::*;

  localparam int RANDOM_ITEMS = 1830;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 32;
  localparam int HOLD_CYCLES  = 400;

  typedef struct packed {
    logic [CHAN_W-1:0]          chan;
    logic signed [SAMPLE_W-1:0] low;
    logic signed [SAMPLE_W-1:0] mid_low;
    logic signed [SAMPLE_W-1:0] mid_high;
    logic signed [SAMPLE_W-1:0] high;
  } band_set_t;

  // Bit-exact copy of the crossover: register values, per-channel history and the
  // band sets still owed by the block.
  class crossover_checker;
    bit                    enabled;
    logic [COEF_REG_W-1:0] coefs[FILTERS];
    int                    x_hist1[DEFAULT_CHANNELS];
    int                    x_hist2[DEFAULT_CHANNELS];
    int                    y_hist1[FILTERS*DEFAULT_CHANNELS];
    int                    y_hist2[FILTERS*DEFAULT_CHANNELS];
    band_set_t             pending_bands[$];
    int                    fails;
    int                    checked;

    function new();
      enabled = 0;
      fails = 0;
      checked = 0;
      foreach (coefs[i]) coefs[i] = '0;
      foreach (x_hist1[i]) begin
        x_hist1[i] = 0;
        x_hist2[i] = 0;
      end
      foreach (y_hist1[i]) begin
        y_hist1[i] = 0;
        y_hist2[i] = 0;
      end
    endfunction

    function void set_register(logic [1:0] idx, logic [DATA_W-1:0] value);
      case (idx)
        REG_ENABLE: enabled = value[0];
        REG_COEF_A, REG_COEF_B, REG_COEF_C: coefs[idx - REG_COEF_A] = value[COEF_REG_W-1:0];
        default: ;
      endcase
    endfunction

    function longint clamp(longint v, int bits);
      longint hi;
      hi = (longint'(1) << (bits - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
    endfunction

    // Q.8 band value rounded half up to an integer sample.
    function logic signed [SAMPLE_W-1:0] to_band(longint q8);
      return SAMPLE_W'(clamp((q8 + 128) >>> 8, SAMPLE_W));
    endfunction

    function void note_sample(logic [CHAN_W-1:0] ch, logic signed [SAMPLE_W-1:0] smp);
      longint                   x;
      longint                   xsum;
      longint                   acc;
      longint                   y[FILTERS];
      logic signed [COEF_W-1:0] g;
      logic signed [COEF_W-1:0] f1;
      logic signed [COEF_W-1:0] f2;
      int                       idx;
      band_set_t                bs;
      if (!enabled || ch >= DEFAULT_CHANNELS) return;
      x = longint'(smp);
      xsum = x + 2 * longint'(x_hist1[ch]) + longint'(x_hist2[ch]);
      for (int k = 0; k < FILTERS; k++) begin
        {g, f1, f2} = coefs[k];
        idx = FILTERS * int'(ch) + k;
        // Numerator is gain * (1, 2, 1); everything is exact in Q.24 here.
        acc = longint'(g) * xsum * 256 - longint'(f1) * y_hist1[idx]
              - longint'(f2) * y_hist2[idx];
        y[k] = clamp((acc + 32768) >>> 16, YHIST_W);
        y_hist2[idx] = y_hist1[idx];
        y_hist1[idx] = int'(y[k]);
      end
      x_hist2[ch] = x_hist1[ch];
      x_hist1[ch] = int'(x);
      bs.chan     = ch;
      bs.low      = to_band(y[0]);
      bs.mid_low  = to_band(y[1] - y[0]);
      bs.mid_high = to_band(y[2] - y[1]);
      bs.high     = to_band(x * 256 - y[2]);
      pending_bands.push_back(bs);
    endfunction

    function void compare_field(string what, longint want, longint got);
      if (want != got) begin
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
        fails++;
      end
    endfunction

    function void check_bands(band_set_t got);
      band_set_t want;
      if (pending_bands.size() == 0) begin
        $display("%0t: unexpected band set: channel %0d bands %0d %0d %0d %0d", $time,
                 got.chan, got.low, got.mid_low, got.mid_high, got.high);
        fails++;
        return;
      end
      want = pending_bands.pop_front();
      checked++;
      compare_field("out_channel", longint'(want.chan), longint'(got.chan));
      compare_field("low_band", longint'(want.low), longint'(got.low));
      compare_field("mid_low_band", longint'(want.mid_low), longint'(got.mid_low));
      compare_field("mid_high_band", longint'(want.mid_high), longint'(got.mid_high));
      compare_field("high_band", longint'(want.high), longint'(got.high));
    endfunction

    function int pending();
      return pending_bands.size();
    endfunction
  endclass

  logic                       clk;
  logic                       rst;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [ADDR_W-1:0]          paddr;
  logic [DATA_W-1:0]          pwdata;
  logic [DATA_W-1:0]          prdata;
  logic                       pready;
  logic                       in_valid;
  logic                       in_ready;
  logic [CHAN_W-1:0]          channel;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       out_valid;
  logic                       out_ready;
  logic [CHAN_W-1:0]          out_channel;
  logic signed [SAMPLE_W-1:0] low_band;
  logic signed [SAMPLE_W-1:0] mid_low_band;
  logic signed [SAMPLE_W-1:0] mid_high_band;
  logic signed [SAMPLE_W-1:0] high_band;

  crossover_checker band_book = new();

  int          quiet_cycles = 0;
  int          burst_left = 0;
  int          walk[DEFAULT_CHANNELS];
  logic [CHAN_W-1:0] last_ch = '0;

  four_band_iir_crossover u_top (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .channel      (channel),
    .sample       (sample),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_channel  (out_channel),
    .low_band     (low_band),
    .mid_low_band (mid_low_band),
    .mid_high_band(mid_high_band),
    .high_band    (high_band)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Handshakes are looked at on the falling edge, where every signal is settled
  // for the rising edge that follows.
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        band_book.note_sample(channel, sample);
      end
      if (out_valid && out_ready) begin
        band_book.check_bands('{chan: out_channel, low: low_band, mid_low: mid_low_band,
                                mid_high: mid_high_band, high: high_band});
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("four_band_iir_crossover_tb failed");
          $finish;
        end
      end
    end
  end

  // Receiver: runs of steady acceptance mixed with random stalls, and one long
  // hold-off so that the input queue fills and in_ready drops.
  initial begin : receiver
    bit held_off;
    held_off = 0;
    out_ready <= 1'b0;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (!held_off && band_book.checked >= 600) begin
        held_off = 1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      case ($urandom_range(0, 3))
        0: begin
          out_ready <= 1'b1;
          repeat ($urandom_range(20, 80)) @(posedge clk);
        end
        default: begin
          repeat ($urandom_range(10, 40)) begin
            out_ready <= ($urandom_range(0, 3) != 0);
            @(posedge clk);
          end
        end
      endcase
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] value);
    logic done;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx) << REG_SEL_LSB;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      done = pready;
      @(posedge clk);
    end while (!done);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    band_book.set_register(idx, value);
  endtask

  task automatic write_coefs(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b,
                             input logic [DATA_W-1:0] c);
    write_reg(REG_COEF_A, a);
    write_reg(REG_COEF_B, b);
    write_reg(REG_COEF_C, c);
  endtask

  // Upper bits of the enable word carry noise; only bit 0 counts.
  task automatic write_enable(input bit on);
    logic [DATA_W-1:0] value;
    value = {$urandom, $urandom};
    value[0] = on;
    write_reg(REG_ENABLE, value);
  endtask

  task automatic send_sample(input logic [CHAN_W-1:0] ch,
                             input logic signed [SAMPLE_W-1:0] smp);
    logic taken;
    in_valid <= 1'b1;
    channel  <= ch;
    sample   <= smp;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
  endtask

  // Sender idles between bursts of random length; many bursts run back to back.
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 64);
    end
    burst_left--;
  endtask

  // Stop offering items and wait until the block has nothing left in flight.
  task automatic end_phase();
    in_valid <= 1'b0;
    while (band_book.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [COEF_W-1:0] q2_16(real v);
    return COEF_W'($rtoi(v * 65536.0 + ((v >= 0.0) ? 0.5 : -0.5)));
  endfunction

  // Bilinear-transform Butterworth low-pass, cutoff given as a fraction of fs.
  function automatic logic [DATA_W-1:0] butterworth(real ratio);
    real k;
    real nrm;
    k = $tan(3.14159265358979 * ratio);
    nrm = 1.0 / (1.0 + 1.41421356237 * k + k * k);
    return DATA_W'({q2_16(k * k * nrm), q2_16(2.0 * (k * k - 1.0) * nrm),
                    q2_16((1.0 - 1.41421356237 * k + k * k) * nrm)});
  endfunction

  function automatic logic [COEF_W-1:0] extreme_field();
    case ($urandom_range(0, 3))
      0: return 18'h1FFFF;
      1: return 18'h20000;
      2: return '0;
      default: return '1;
    endcase
  endfunction

  function automatic logic [CHAN_W-1:0] next_channel();
    if ($urandom_range(0, 2) != 0) last_ch = CHAN_W'($urandom_range(0, DEFAULT_CHANNELS - 1));
    return last_ch;
  endfunction

  // Mostly a random walk per channel, like a band-limited signal, with noise and
  // full-scale values mixed in.
  function automatic logic signed [SAMPLE_W-1:0] next_sample(logic [CHAN_W-1:0] ch);
    int v;
    case ($urandom_range(0, 15))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2: return '0;
      3, 4: return SAMPLE_W'($urandom);
      default: begin
        v = walk[ch] + int'($urandom_range(0, 1 << 18)) - (1 << 17);
        if (v > 8388607) v = 8388607;
        if (v < -8388608) v = -8388608;
        walk[ch] = v;
        return SAMPLE_W'(v);
      end
    endcase
  endfunction

  initial begin : stimulus
    int  band_count;
    int  n;
    int  kind;
    bit  on;
    real fa;
    real fb;
    real fc;
    band_count = 0;
    foreach (walk[i]) walk[i] = 0;
    rst      <= 1'b1;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    in_valid <= 1'b0;
    channel  <= '0;
    sample   <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Disabled after reset: items are taken and dropped.
    send_sample(CHAN_W'(0), 24'sh7FFFFF);
    send_sample(CHAN_W'(7), 24'sh800000);
    send_sample(CHAN_W'(3), 24'sh123456);
    end_phase();

    // Zero coefficients: every low-pass output is zero, the high band is the input.
    write_enable(1'b1);
    send_sample(CHAN_W'(0), 24'sh7FFFFF);
    send_sample(CHAN_W'(1), 24'sh800000);
    send_sample(CHAN_W'(2), '0);
    send_sample(CHAN_W'(3), -24'sd1);
    end_phase();

    // A real crossover: steps and full-scale alternation, same channel back to back.
    write_coefs(butterworth(0.01), butterworth(0.05), butterworth(0.2));
    repeat (4) send_sample(CHAN_W'(5), 24'sh7FFFFF);
    send_sample(CHAN_W'(6), 24'sh800000);
    send_sample(CHAN_W'(7), 24'sh7FFFFF);
    send_sample(CHAN_W'(7), 24'sh800000);
    send_sample(CHAN_W'(7), 24'sh7FFFFF);
    send_sample(CHAN_W'(0), '0);
    send_sample(CHAN_W'(5), -24'sd1);
    end_phase();

    // Unstable sections at the coefficient limits drive the filters into saturation.
    write_coefs(DATA_W'({18'h1FFFF, 18'h20000, 18'h1FFFF}),
                DATA_W'({18'h20000, 18'h1FFFF, 18'h20000}),
                DATA_W'({54{1'b1}}));
    repeat (4) send_sample(CHAN_W'(1), 24'sh7FFFFF);
    repeat (4) send_sample(CHAN_W'(2), 24'sh800000);
    end_phase();

    while (band_count < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        fa = 0.002 + 0.03 * ($urandom_range(0, 1000) / 1000.0);
        fb = fa + 0.01 + 0.1 * ($urandom_range(0, 1000) / 1000.0);
        fc = fb + 0.02 + 0.2 * ($urandom_range(0, 1000) / 1000.0);
        write_coefs(butterworth(fa), butterworth(fb), butterworth(fc));
      end else if (kind < 8) begin
        write_coefs({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
      end else begin
        write_coefs(DATA_W'({extreme_field(), extreme_field(), extreme_field()}),
                    DATA_W'({extreme_field(), extreme_field(), extreme_field()}),
                    DATA_W'({extreme_field(), extreme_field(), extreme_field()}));
      end
      on = ($urandom_range(0, 7) != 0);
      write_enable(on);
      n = on ? $urandom_range(60, 220) : $urandom_range(8, 30);
      repeat (n) begin
        send_sample(next_channel(), next_sample(last_ch));
        pace();
        if (on) band_count++;
      end
      end_phase();
    end

    if (band_book.fails == 0 && band_book.pending() == 0) begin
      $display("four_band_iir_crossover_tb passed");
    end else begin
      $display("four_band_iir_crossover_tb failed");
    end
    $finish;
  end

endmodule
